// ===== hdl/stp_pkg.sv =====
// shared types, constants and coil pattern lookup for the half-step positioner
// no dependencies; imported by stp_step, stepper_half_step_positioner and the bench
package stp_pkg;

    localparam int unsigned PosW   = 16;
    localparam int unsigned HoldW  = 16;
    localparam int unsigned RepW   = 12;
    localparam int unsigned PhaseW = 3;
    localparam int unsigned CoilW  = 4;

    // reset values of the configuration registers
    localparam logic [HoldW-1:0] HoldReset = 16'd1000;
    localparam logic [RepW-1:0]  RepReset  = 12'd0;

    // item kinds carried on tuser
    localparam logic CmdTick   = 1'b0;
    localparam logic CmdTarget = 1'b1;

    // register addresses, decoded by paddr[2]
    localparam logic RegHold = 1'b0;
    localparam logic RegReps = 1'b1;

    typedef struct packed {
        logic [PosW-1:0]   current_pos;
        logic [PosW-1:0]   goal_pos;
        logic              moving;
        logic              going_up;
        logic [PhaseW-1:0] phase_index;
        logic [HoldW-1:0]  hold_count;
        logic [RepW-1:0]   repeat_count;
        logic              gap_tick;
        logic [CoilW-1:0]  coil_reg;
    } t_stp_state;

    localparam logic [7:0][CoilW-1:0] PatUp = {
        4'd9, 4'd8, 4'd12, 4'd4, 4'd6, 4'd2, 4'd3, 4'd1
    };
    localparam logic [7:0][CoilW-1:0] PatDown = {
        4'd9, 4'd1, 4'd3, 4'd2, 4'd6, 4'd4, 4'd12, 4'd8
    };

    function automatic logic [CoilW-1:0] coil_pattern(input logic up,
                                                      input logic [PhaseW-1:0] ph);
        return up ? PatUp[ph] : PatDown[ph];
    endfunction

endpackage

// ===== hdl/stp_step.sv =====
// next-state logic for one word: target set or one tick of the half-step sequence
// depends on stp_pkg
module stp_step (
    input  stp_pkg::t_stp_state     i_st,
    input  logic                    i_cmd,
    input  logic [15:0]             i_target,
    input  logic [15:0]             i_hold_cfg,
    input  logic [11:0]             i_reps_cfg,
    output stp_pkg::t_stp_state     o_st
);
    import stp_pkg::*;

    logic             unit_start;
    logic             dir_up;
    logic [HoldW-1:0] hold_inc;
    logic [HoldW-1:0] hold_lim;
    logic             phase_done;

    assign unit_start = (i_st.hold_count == '0) && (i_st.phase_index == '0)
                        && (i_st.repeat_count == '0);
    assign dir_up     = unit_start ? ($signed(i_st.current_pos) < $signed(i_st.goal_pos))
                                   : i_st.going_up;
    assign hold_inc   = i_st.hold_count + HoldW'(1);
    assign hold_lim   = (i_hold_cfg == '0) ? HoldW'(1) : i_hold_cfg;
    assign phase_done = hold_inc >= hold_lim;

    always_comb begin
        o_st = i_st;
        if (i_cmd == CmdTarget) begin
            // ignored while a move is running
            if (!i_st.moving) begin
                o_st.goal_pos     = i_target;
                o_st.phase_index  = '0;
                o_st.hold_count   = '0;
                o_st.repeat_count = '0;
                o_st.gap_tick     = 1'b0;
                o_st.moving       = (i_target != i_st.current_pos);
            end
        end else if (!i_st.moving) begin
            o_st.coil_reg = '0;
        end else if (i_st.gap_tick) begin
            o_st.gap_tick = 1'b0;
            o_st.coil_reg = '0;
            if (i_st.current_pos == i_st.goal_pos) begin
                o_st.moving = 1'b0;
            end
        end else begin
            o_st.going_up = dir_up;
            if (unit_start) begin
                o_st.current_pos = dir_up ? i_st.current_pos + PosW'(1)
                                          : i_st.current_pos - PosW'(1);
            end
            o_st.coil_reg   = coil_pattern(dir_up, i_st.phase_index);
            o_st.hold_count = hold_inc;
            if (phase_done) begin
                o_st.hold_count  = '0;
                o_st.phase_index = i_st.phase_index + PhaseW'(1);
                if (i_st.phase_index == '1) begin
                    if (i_st.repeat_count >= i_reps_cfg) begin
                        o_st.repeat_count = '0;
                        o_st.gap_tick     = 1'b1;
                    end else begin
                        o_st.repeat_count = i_st.repeat_count + RepW'(1);
                    end
                end
            end
        end
    end

endmodule

// ===== hdl/stepper_half_step_positioner.sv =====
// path: input register, then the axis state, which doubles as the result register
// one word per cycle unless stalled; the axis state updates in one registered step
// input register and result register are each released when the next side takes them
// reset (i_rst_n low, synchronous): position, goal and counters cleared, coils off,
// phase_hold_ticks back to 1000 and sequence_repeats to 0
module stepper_half_step_positioner (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] target_position
    input  logic [0:0]  s_axis_tuser,   // [0] command
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [3:0] coils, [19:4] position, [20] busy_res
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import stp_pkg::*;

    // configuration registers
    logic [HoldW-1:0] r_hold_cfg;
    logic [RepW-1:0]  r_reps_cfg;
    logic             cfg_wr;

    // input register
    logic             r_in_valid;
    logic             r_in_cmd;
    logic [PosW-1:0]  r_in_target;

    // axis state doubles as the result register
    t_stp_state       r_st;
    t_stp_state       n_st;
    logic             r_out_valid;

    logic             advance;
    logic             fire;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == RegReps) ? {20'd0, r_reps_cfg} : {16'd0, r_hold_cfg};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_cfg <= HoldReset;
            r_reps_cfg <= RepReset;
        end else if (cfg_wr) begin
            if (paddr[2] == RegHold) begin
                r_hold_cfg <= pwdata[HoldW-1:0];
            end else begin
                r_reps_cfg <= pwdata[RepW-1:0];
            end
        end
    end

    // result slot frees when empty or being taken; the state only steps then,
    // so the visible result always matches the state it came from
    assign advance       = !r_out_valid || m_axis_tready;
    assign fire          = r_in_valid && advance;
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_cmd    <= s_axis_tuser[0];
            r_in_target <= s_axis_tdata;
        end
    end

    stp_step u_step (
        .i_st       (r_st),
        .i_cmd      (r_in_cmd),
        .i_target   (r_in_target),
        .i_hold_cfg (r_hold_cfg),
        .i_reps_cfg (r_reps_cfg),
        .o_st       (n_st)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_st <= n_st;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'd0, r_st.moving, r_st.current_pos, r_st.coil_reg};

`ifndef SYNTHESIS
    // coils are always off once the axis is idle
    a_idle_coils_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_st.moving |-> (r_st.coil_reg == '0))
        else $error("coils driven while idle");

    // a pending gap tick only exists inside a move
    a_gap_in_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.gap_tick |-> r_st.moving)
        else $error("gap tick outside a move");

    // position moves by at most one unit per word
    a_pos_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> (r_st.current_pos == $past(r_st.current_pos))
              || (r_st.current_pos == $past(r_st.current_pos) + 16'd1)
              || (r_st.current_pos == $past(r_st.current_pos) - 16'd1))
        else $error("position jumped by more than one unit");

    // axis state only changes when a word is processed
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !fire |=> $stable(r_st))
        else $error("state changed without a word");
`endif

endmodule

// ===== bench/stepper_half_step_positioner_tb.sv =====
// self-checking bench for the half-step positioner: moves, ignored targets, odd register settings
// depends on stp_pkg (command kinds, register addresses) and the stepper_half_step_positioner rtl
module stepper_half_step_positioner_tb;
    import stp_pkg::*;

    // the slowest legal run stays far below this
    localparam int unsigned CycleLimit = 3000000;

    // expected coil drive word, one per accepted input word
    typedef struct packed {
        logic [3:0]  coils;
        logic [15:0] position;
        logic        busy;
    } t_drive;

    class coil_scoreboard;
        logic [15:0] hold_cfg;
        logic [11:0] reps_cfg;
        logic [15:0] pos;
        logic [15:0] goal;
        logic        moving;
        logic        going_up;
        logic [2:0]  phase;
        logic [15:0] hold_cnt;
        logic [11:0] rep_cnt;
        logic        gap;
        logic [3:0]  coil;
        t_drive      drive_q[$];
        int          fail_count;

        function new();
            hold_cfg   = 16'd1000;
            reps_cfg   = 12'd0;
            pos        = '0;
            goal       = '0;
            moving     = 1'b0;
            going_up   = 1'b0;
            phase      = '0;
            hold_cnt   = '0;
            rep_cnt    = '0;
            gap        = 1'b0;
            coil       = '0;
            fail_count = 0;
        endfunction

        function void write_reg(logic sel, logic [31:0] value);
            if (sel == RegHold) hold_cfg = value[15:0];
            else reps_cfg = value[11:0];
        endfunction

        // clockwise nibbles 1,3,2,6,4,12,8,9 and counter-clockwise 8,12,4,6,2,3,1,9
        function logic [3:0] half_step(logic up, logic [2:0] ph);
            logic [31:0] seq;
            seq = up ? 32'h98C46231 : 32'h913264C8;
            return seq[ph*4 +: 4];
        endfunction

        function void step_tick();
            logic [15:0] hold_eff;
            if (!moving) begin
                coil = '0;
                return;
            end
            // coils-off tick between units, the move ends here on arrival
            if (gap) begin
                gap  = 1'b0;
                coil = '0;
                if (pos == goal) moving = 1'b0;
                return;
            end
            // position moves when a unit begins
            if (hold_cnt == '0 && phase == '0 && rep_cnt == '0) begin
                going_up = $signed(pos) < $signed(goal);
                pos      = going_up ? pos + 16'd1 : pos - 16'd1;
            end
            coil     = half_step(going_up, phase);
            hold_cnt = hold_cnt + 16'd1;
            hold_eff = (hold_cfg == '0) ? 16'd1 : hold_cfg;
            if (hold_cnt >= hold_eff) begin
                hold_cnt = '0;
                phase    = phase + 3'd1;
                if (phase == '0) begin
                    if (rep_cnt >= reps_cfg) begin
                        rep_cnt = '0;
                        gap     = 1'b1;
                    end else begin
                        rep_cnt = rep_cnt + 12'd1;
                    end
                end
            end
        endfunction

        function void note_word(logic cmd, logic [15:0] tgt);
            t_drive d;
            if (cmd == CmdTarget) begin
                // a target while busy is dropped
                if (!moving) begin
                    goal     = tgt;
                    phase    = '0;
                    hold_cnt = '0;
                    rep_cnt  = '0;
                    gap      = 1'b0;
                    if (goal != pos) moving = 1'b1;
                end
            end else begin
                step_tick();
            end
            d.coils    = coil;
            d.position = pos;
            d.busy     = moving;
            drive_q.push_back(d);
        endfunction

        function void check_word(logic [23:0] tdata);
            t_drive want;
            if (drive_q.size() == 0) begin
                $display("%0t: unexpected result word %h", $time, tdata);
                fail_count++;
                return;
            end
            want = drive_q.pop_front();
            if (tdata[3:0] !== want.coils) begin
                $display("%0t: coils expected %h actual %h", $time, want.coils, tdata[3:0]);
                fail_count++;
            end
            if (tdata[19:4] !== want.position) begin
                $display("%0t: position expected %0d actual %0d", $time,
                         $signed(want.position), $signed(tdata[19:4]));
                fail_count++;
            end
            if (tdata[20] !== want.busy) begin
                $display("%0t: busy expected %b actual %b", $time, want.busy, tdata[20]);
                fail_count++;
            end
        endfunction

        function int pending();
            return drive_q.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;   // [15:0] target_position
    logic [0:0]  s_axis_tuser = '0;   // [0] command
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;        // [3:0] coils, [19:4] position, [20] busy_res
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    coil_scoreboard sb = new();
    int unsigned    cycle_count = 0;
    int             burst_left = 0;

    stepper_half_step_positioner uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 i_clk = ~i_clk;

    // result side: check what was taken at this edge, then pick the next ready
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata);
        cycle_count <= cycle_count + 1;
        case (cycle_count[9:8])
            2'd0: m_axis_tready <= 1'b1;
            2'd1: m_axis_tready <= 1'($urandom_range(0, 1));
            2'd2: m_axis_tready <= (cycle_count[1:0] == 2'd0);
            default: m_axis_tready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // one input word, sent in bursts with random gaps between them
    task automatic push_word(logic cmd, logic [15:0] data);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(1, 12);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= data;
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        sb.note_word(cmd, data);
    endtask

    // quiet input and wait until every result word is out
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_write(logic sel, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.write_reg(sel, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic finish_move();
        while (sb.moving) push_word(CmdTick, 16'($urandom));
    endtask

    // one register setting, then moves of up to reach units with ticks and noise
    task automatic run_phase(logic [15:0] hold, logic [11:0] reps, int quota, int reach);
        int counted;
        int r;
        int d;
        counted = 0;
        settle();
        apb_write(RegHold, {16'($urandom), hold});
        apb_write(RegReps, {20'($urandom), reps});
        while (counted < quota) begin
            if (!sb.moving) begin
                r = $urandom_range(0, 9);
                if (r < 7 && reach > 0) begin
                    d = $urandom_range(1, reach);
                    if ($urandom_range(0, 1)) d = -d;
                    push_word(CmdTarget, 16'(int'($signed(sb.pos)) + d));
                    counted++;
                end else if (r < 8 || reach == 0) begin
                    // target equal to the position keeps the axis idle
                    push_word(CmdTarget, sb.pos);
                    counted++;
                end else begin
                    push_word(CmdTick, 16'($urandom));
                end
            end else if ($urandom_range(0, 15) == 0) begin
                // target while busy, dropped by the block
                push_word(CmdTarget, 16'($urandom));
            end else begin
                push_word(CmdTick, 16'($urandom));
                counted++;
            end
        end
        finish_move();
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: idle tick and a target equal to the position
        push_word(CmdTick, 16'h0000);
        push_word(CmdTarget, 16'h0000);
        settle();
        apb_write(RegHold, 32'd1);
        apb_write(RegReps, 32'd0);

        // one unit up, extreme targets thrown at the busy axis, then one unit down
        push_word(CmdTarget, 16'h0001);
        repeat (3) push_word(CmdTick, 16'hFFFF);
        push_word(CmdTarget, 16'h8000);
        push_word(CmdTarget, 16'h7FFF);
        push_word(CmdTarget, 16'hFFFF);
        push_word(CmdTarget, 16'h0000);
        finish_move();
        push_word(CmdTarget, 16'h0000);
        finish_move();

        run_phase(16'd1, 12'd0, 150, 3);
        run_phase(16'd0, 12'd0, 60, 3);      // zero hold acts as one tick
        run_phase(16'd2, 12'd1, 150, 2);
        run_phase(16'd3, 12'd0, 100, 3);
        run_phase(16'd1, 12'd2, 100, 2);
        run_phase(16'($urandom_range(1, 4)), 12'($urandom_range(0, 2)), 150, 3);
        // largest settings only while idle; single units with more repeats and a longer hold
        run_phase(16'hFFFF, 12'hFFF, 6, 0);
        run_phase(16'd1, 12'd15, 2, 1);
        run_phase(16'd20, 12'd0, 2, 1);

        settle();
        repeat (10) @(posedge i_clk);
        if (sb.fail_count == 0 && sb.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        repeat (CycleLimit) @(posedge i_clk);
        $display("timeout after %0d cycles, %0d words pending", CycleLimit, sb.pending());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
